// File: hw/rtl/utv_pkg.sv
package utv_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } utv_item_t;

  localparam logic [4:0] TS_LENGTH      = 5'd20;
  localparam logic [4:0] POS_SAT        = 5'd21;
  localparam logic [4:0] POS_YEAR_HI    = 5'd1;
  localparam logic [4:0] POS_YEAR_TENS  = 5'd2;
  localparam logic [4:0] POS_YEAR_LAST  = 5'd3;
  localparam logic [4:0] POS_DASH_MONTH = 5'd4;
  localparam logic [4:0] POS_MONTH_HI   = 5'd5;
  localparam logic [4:0] POS_MONTH_LO   = 5'd6;
  localparam logic [4:0] POS_DASH_DAY   = 5'd7;
  localparam logic [4:0] POS_DAY_HI     = 5'd8;
  localparam logic [4:0] POS_DAY_LO     = 5'd9;
  localparam logic [4:0] POS_TEE        = 5'd10;
  localparam logic [4:0] POS_HOUR_HI    = 5'd11;
  localparam logic [4:0] POS_HOUR_LO    = 5'd12;
  localparam logic [4:0] POS_COLON_MIN  = 5'd13;
  localparam logic [4:0] POS_MIN_HI     = 5'd14;
  localparam logic [4:0] POS_COLON_SEC  = 5'd16;
  localparam logic [4:0] POS_SEC_HI     = 5'd17;
  localparam logic [4:0] POS_ZULU       = 5'd19;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_TEE   = 8'h54;
  localparam logic [7:0] CHAR_ZULU  = 8'h5A;

  localparam logic [13:0] MIN_YEAR  = 14'd2000;
  localparam logic [6:0]  MAX_HOUR  = 7'd23;
  localparam logic [6:0]  MAX_MINSEC = 7'd59;
  localparam logic [6:0]  MONTH_FEB = 7'd2;
  localparam logic [6:0]  MONTH_DEC = 7'd12;
  localparam logic [4:0]  LEAP_FEB_DAYS = 5'd29;

  function automatic logic [4:0] days_in_month(input logic [3:0] month);
    logic [4:0] days;
    case (month)
      4'd2:                      days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
      default:                   days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

// File: hw/rtl/utv_check.sv
module utv_check import utv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  utv_item_t item,
  input  logic      advance,
  output logic      result
);

  logic [4:0]  char_position, char_position_next;
  logic        failed_flag;
  logic [13:0] year_value, year_value_next;
  logic [6:0]  digit_pair_value, digit_pair_value_next;
  logic [6:0]  month_value, month_value_next;
  logic [1:0]  year_mod4, year_mod4_next;
  logic [1:0]  century_mod4, century_mod4_next;
  logic        tens_zero, tens_zero_next;
  logic        leap, leap_next;

  logic        is_digit;
  logic [3:0]  digit;
  logic [13:0] year_calc;
  logic [6:0]  pair_calc;
  logic [4:0]  max_day;
  logic        month_ok;
  logic        fail;

  always_comb begin
    is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
    digit    = is_digit ? 4'(item.char_code - CHAR_ZERO) : 4'd0;
    // times ten as shift and add
    year_calc = 14'({1'b0, year_value, 3'b000} + {3'b000, year_value, 1'b0}
                    + 18'(digit));
    pair_calc = 7'({1'b0, digit_pair_value, 3'b000} + {3'b000, digit_pair_value, 1'b0}
                   + 11'(digit));
    month_ok  = (month_value >= 7'd1) && (month_value <= MONTH_DEC);
    max_day   = (month_value == MONTH_FEB && leap) ? LEAP_FEB_DAYS
                                                   : days_in_month(month_value[3:0]);

    year_value_next       = year_value;
    digit_pair_value_next = digit_pair_value;
    month_value_next      = month_value;
    year_mod4_next        = year_mod4;
    century_mod4_next     = century_mod4;
    tens_zero_next        = tens_zero;
    leap_next             = leap;
    fail                  = 1'b0;

    if (char_position >= TS_LENGTH) begin
      fail = 1'b1;
    end else begin
      case (char_position) inside
        POS_DASH_MONTH, POS_DASH_DAY: fail = (item.char_code != CHAR_DASH);
        POS_TEE:                      fail = (item.char_code != CHAR_TEE);
        POS_COLON_MIN, POS_COLON_SEC: fail = (item.char_code != CHAR_COLON);
        POS_ZULU:                     fail = (item.char_code != CHAR_ZULU);
        [5'd0:POS_YEAR_LAST]: begin
          fail = !is_digit;
          year_value_next = year_calc;
          // (10y + d) mod 4 = (2y + d) mod 4
          year_mod4_next = 2'({year_mod4[0], 1'b0} + digit[1:0]);
          if (char_position == POS_YEAR_HI) begin
            century_mod4_next = year_mod4_next;
          end
          if (char_position == POS_YEAR_TENS) begin
            tens_zero_next = (digit == 4'd0);
          end
          if (char_position == POS_YEAR_LAST) begin
            if (year_calc < MIN_YEAR) begin
              fail = 1'b1;
            end
            if (tens_zero && digit == 4'd0) begin
              leap_next = (century_mod4 == 2'd0);
            end else begin
              leap_next = (year_mod4_next == 2'd0);
            end
          end
        end
        POS_MONTH_HI, POS_DAY_HI, POS_HOUR_HI, POS_MIN_HI, POS_SEC_HI: begin
          fail = !is_digit;
          digit_pair_value_next = 7'(digit);
        end
        default: begin
          fail = !is_digit;
          digit_pair_value_next = pair_calc;
          case (char_position)
            POS_MONTH_LO: begin
              month_value_next = pair_calc;
              if (pair_calc < 7'd1 || pair_calc > MONTH_DEC) begin
                fail = 1'b1;
              end
            end
            POS_DAY_LO: begin
              if (!month_ok || pair_calc < 7'd1 || pair_calc > {2'b00, max_day}) begin
                fail = 1'b1;
              end
            end
            POS_HOUR_LO: begin
              if (pair_calc > MAX_HOUR) begin
                fail = 1'b1;
              end
            end
            default: begin
              if (pair_calc > MAX_MINSEC) begin
                fail = 1'b1;
              end
            end
          endcase
        end
      endcase
    end

    char_position_next = (char_position < POS_SAT) ? char_position + 5'd1 : char_position;
    result = !(failed_flag || fail) && (char_position == POS_ZULU);
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && item.last_char)) begin
      char_position    <= '0;
      failed_flag      <= 1'b0;
      year_value       <= '0;
      digit_pair_value <= '0;
      month_value      <= '0;
      year_mod4        <= '0;
      century_mod4     <= '0;
      tens_zero        <= 1'b0;
      leap             <= 1'b0;
    end else if (advance) begin
      char_position    <= char_position_next;
      failed_flag      <= failed_flag | fail;
      year_value       <= year_value_next;
      digit_pair_value <= digit_pair_value_next;
      month_value      <= month_value_next;
      year_mod4        <= year_mod4_next;
      century_mod4     <= century_mod4_next;
      tens_zero        <= tens_zero_next;
      leap             <= leap_next;
    end
  end

endmodule

// File: hw/rtl/utc_timestamp_validator.sv
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------
// char     | in        | char_valid / char_stall   | char_code[7:0], last_char
// result   | out       | result_valid / result_stall | timestamp_valid
//
// one character per cycle while char_stall is low; the character check sits
// between the input register and the result register, so result_valid rises
// once its last character has passed through both registers.
// rst clears the position counter, the flags and both valid bits.
// char_stall rises only when a last character waits on a full, stalled
// result register; other characters keep flowing.
module utc_timestamp_validator import utv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       timestamp_valid
);

  logic      in_valid;
  utv_item_t in_item;
  logic      out_free;
  logic      advance;
  logic      check_result;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_valid && (!in_item.last_char || out_free);
  assign char_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!char_stall) begin
      in_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall) begin
      in_item.char_code <= char_code;
      in_item.last_char <= last_char;
    end
  end

  utv_check u_check (
    .clk     (clk),
    .rst     (rst),
    .item    (in_item),
    .advance (advance),
    .result  (check_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && in_item.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      timestamp_valid <= check_result;
    end
  end

endmodule

// File: hw/rtl/utv_checker.sv
module utv_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic       last_char,
  input logic       result_valid,
  input logic       result_stall,
  input logic       timestamp_valid
);

  // a held result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(timestamp_valid))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // with an empty result register nothing can hold up the input
  assert property (@(posedge clk) !result_valid |-> !char_stall)
    else $error("input stalled with empty result register");

  // a new result follows an earlier last-character transfer
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(char_valid && !char_stall && last_char, 2))
    else $error("result without last character");

endmodule

bind utc_timestamp_validator utv_checker u_utv_checker (
  .clk             (clk),
  .rst             (rst),
  .char_valid      (char_valid),
  .char_stall      (char_stall),
  .last_char       (last_char),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .timestamp_valid (timestamp_valid)
);
